[hdl/tcf_pkg.sv]
// ----------------------------------------------------------------------------
// tcf_pkg
// Shared constants, types and character helpers for the command framer.
// ----------------------------------------------------------------------------
package tcf_pkg;

	localparam int MAX_LEN_DEF = 32;

	localparam logic [7:0] CH_START = 8'h3A;  // ':'
	localparam logic [7:0] CH_END   = 8'h23;  // '#'

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_FULL = 2'd1;
	localparam logic [1:0] ST_BAD  = 2'd2;

	localparam logic KIND_STATUS = 1'b0;
	localparam logic KIND_BYTE   = 1'b1;

	localparam int NUM_FAMILIES = 23;

	// The position in this list, plus one, is the family code.
	localparam logic [7:0] FAMILY_LETTERS [NUM_FAMILIES] = '{
		8'h41, 8'h42, 8'h43, 8'h44, 8'h66, 8'h46, 8'h47, 8'h67, 8'h68, 8'h48, 8'h49, 8'h4C,
		8'h4D, 8'h50, 8'h51, 8'h72, 8'h52, 8'h53, 8'h54, 8'h55, 8'h57, 8'h58, 8'h3F
	};

	localparam logic [7:0] CH_S = 8'h53;
	localparam logic [7:0] CH_R = 8'h52;
	localparam logic [7:0] CH_T = 8'h54;
	localparam logic [7:0] CH_F = 8'h46;
	localparam logic [7:0] CH_B = 8'h42;
	localparam logic [7:0] CH_G_LOWER = 8'h67;
	localparam logic [7:0] CH_L = 8'h4C;

	typedef struct packed {
		logic       store_wr;
		logic       fill_clr;
		logic       load_status;
		logic [1:0] status;
		logic       load_byte;
		logic       ptr_init;
		logic       ptr_inc;
	} tcf_cmd_t;

	typedef struct packed {
		logic out_free;
		logic fill_zero;
		logic fill_one;
		logic fill_full;
		logic is_start;
		logic is_end;
		logic ptr_last;
	} tcf_stat_t;

	function automatic logic [4:0] family_of(input logic [7:0] c);
		logic [4:0] fam;
		fam = 5'd0;
		for (int i = 0; i < NUM_FAMILIES; i++) begin
			if (FAMILY_LETTERS[i] == c) begin
				fam = 5'(i + 1);
			end
		end
		return fam;
	endfunction

	function automatic logic takes_params(input logic [7:0] c);
		return (c == CH_S) || (c == CH_R) || (c == CH_T) || (c == CH_F) ||
			(c == CH_B) || (c == CH_G_LOWER) || (c == CH_L);
	endfunction

endpackage

[hdl/tcf_dp.sv]
// ----------------------------------------------------------------------------
// tcf_dp
// Byte store, fill count, family capture, read pointer and result register.
// ----------------------------------------------------------------------------
module tcf_dp #(
	parameter int MAX_LEN = tcf_pkg::MAX_LEN_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  tcf_pkg::tcf_cmd_t  cmd,
	output tcf_pkg::tcf_stat_t stat,
	input  logic [7:0]       char_in,
	output logic             res_valid,
	input  logic             res_stall,
	output logic             kind,
	output logic [1:0]       status,
	output logic [4:0]       family_code,
	output logic [7:0]       body_byte,
	output logic             in_parameters,
	output logic             last
);
	import tcf_pkg::*;

	localparam int AW = $clog2(MAX_LEN);
	localparam int FW = $clog2(MAX_LEN + 1);

	logic [7:0]    mem [MAX_LEN];
	logic [7:0]    rd_data_q;
	logic [FW-1:0] fill_q;
	logic [AW-1:0] ptr_q;
	logic [4:0]    fam_q;
	logic          tp_q;
	logic          res_valid_q;
	logic          kind_q;
	logic [1:0]    status_q;
	logic [4:0]    family_q;
	logic [7:0]    byte_q;
	logic          param_q;
	logic          last_q;
	logic          params_on;

	// The body takes parameters only when it is longer than the two-letter name.
	assign params_on = tp_q && (fill_q >= FW'(4));

	always_comb begin
		stat.out_free  = !res_valid_q || !res_stall;
		stat.fill_zero = (fill_q == '0);
		stat.fill_one  = (fill_q == FW'(1));
		stat.fill_full = (fill_q >= FW'(MAX_LEN));
		stat.is_start  = (char_in == CH_START);
		stat.is_end    = (char_in == CH_END);
		stat.ptr_last  = (FW'(ptr_q) == fill_q - FW'(1));
	end

	always_ff @(posedge clk) begin
		if (cmd.store_wr) begin
			mem[fill_q[AW-1:0]] <= char_in;
		end
		rd_data_q <= mem[ptr_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (cmd.fill_clr) begin
			fill_q <= '0;
		end else if (cmd.store_wr) begin
			fill_q <= fill_q + FW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.store_wr && (fill_q == FW'(1))) begin
			fam_q <= family_of(char_in);
			tp_q  <= takes_params(char_in);
		end
		if (cmd.ptr_init) begin
			ptr_q <= AW'(1);
		end else if (cmd.ptr_inc) begin
			ptr_q <= ptr_q + AW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (cmd.load_status || cmd.load_byte) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_status) begin
			kind_q   <= KIND_STATUS;
			status_q <= cmd.status;
			family_q <= 5'd0;
			byte_q   <= 8'd0;
			param_q  <= 1'b0;
			last_q   <= 1'b1;
		end else if (cmd.load_byte) begin
			kind_q   <= KIND_BYTE;
			status_q <= ST_OK;
			family_q <= fam_q;
			byte_q   <= rd_data_q;
			param_q  <= params_on && (ptr_q >= AW'(3));
			last_q   <= stat.ptr_last;
		end
	end

	assign res_valid     = res_valid_q;
	assign kind          = kind_q;
	assign status        = status_q;
	assign family_code   = family_q;
	assign body_byte     = byte_q;
	assign in_parameters = param_q;
	assign last          = last_q;

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FW'(MAX_LEN))
		else $error("fill count ran past the store depth");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && res_stall) |-> !(cmd.load_status || cmd.load_byte))
		else $error("result register loaded while its request was held");

	a_single_load: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.load_status && cmd.load_byte))
		else $error("status and byte loaded together");

	a_no_write_on_full: assert property (@(posedge clk) disable iff (!arst_n)
		(fill_q >= FW'(MAX_LEN)) |-> !cmd.store_wr)
		else $error("store written while full");

endmodule

[hdl/tcf_ctrl.sv]
// ----------------------------------------------------------------------------
// tcf_ctrl
// Controller: decides each request's outcome and walks the store on '#'.
// ----------------------------------------------------------------------------
module tcf_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cmd_valid,
	output logic               cmd_stall,
	input  logic               action,
	input  tcf_pkg::tcf_stat_t stat,
	output tcf_pkg::tcf_cmd_t  cmd
);
	import tcf_pkg::*;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_RD   = 2'd1;
	localparam logic [1:0] S_WR   = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       accept;

	assign cmd_stall = !((state_q == S_IDLE) && stat.out_free);
	assign accept    = cmd_valid && !cmd_stall;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					cmd.load_status = 1'b1;
					cmd.status      = ST_OK;
					if (action) begin
						cmd.fill_clr = 1'b1;
					end else if (stat.fill_full) begin
						cmd.status = ST_FULL;
					end else if (stat.fill_zero) begin
						if (stat.is_start) begin
							cmd.store_wr = 1'b1;
						end else begin
							cmd.status = ST_BAD;
						end
					end else if (!stat.is_end) begin
						cmd.store_wr = 1'b1;
					end else if (stat.fill_one) begin
						cmd.status = ST_BAD;
					end else begin
						// A complete command gives only body bytes, no status result.
						cmd.load_status = 1'b0;
						cmd.ptr_init    = 1'b1;
						state_d         = S_RD;
					end
				end
			end
			S_RD: begin
				state_d = S_WR;
			end
			S_WR: begin
				if (stat.out_free) begin
					cmd.load_byte = 1'b1;
					if (stat.ptr_last) begin
						cmd.fill_clr = 1'b1;
						state_d      = S_IDLE;
					end else begin
						cmd.ptr_inc = 1'b1;
						state_d     = S_RD;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	a_rd_to_wr: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RD) |=> (state_q == S_WR))
		else $error("read cycle not followed by the write cycle");

	a_stall_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> cmd_stall)
		else $error("request taken while emitting a command");

	a_clear_on_finish: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == S_WR) && (state_d == S_IDLE)) |-> (cmd.fill_clr && cmd.load_byte))
		else $error("command finished without clearing the store");

endmodule

[hdl/telescope_command_framer.sv]
// ----------------------------------------------------------------------------
// telescope_command_framer
// Frames ':' body '#' serial commands and emits the body bytes as a run.
// ----------------------------------------------------------------------------
// Each request either feeds one character or clears the buffer. A request that
// does not complete a command gives one status result from the output register;
// the next request is taken as soon as that register is free or being drained.
// A '#' that ends a body of n bytes gives n results and stalls requests until the
// last one is loaded: the byte store has one registered read port, so each body
// byte passes through a read state and then a load state.
// The store needs no clearing after reset; only written entries are read.
module telescope_command_framer #(
	parameter int MAX_LEN = tcf_pkg::MAX_LEN_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cmd_valid,
	output logic       cmd_stall,
	input  logic       action,
	input  logic [7:0] char_in,
	output logic       res_valid,
	input  logic       res_stall,
	output logic       kind,
	output logic [1:0] status,
	output logic [4:0] family_code,
	output logic [7:0] body_byte,
	output logic       in_parameters,
	output logic       last
);
	import tcf_pkg::*;

	tcf_cmd_t  cmd;
	tcf_stat_t stat;

	tcf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.action    (action),
		.stat      (stat),
		.cmd       (cmd)
	);

	tcf_dp #(
		.MAX_LEN (MAX_LEN)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.char_in       (char_in),
		.res_valid     (res_valid),
		.res_stall     (res_stall),
		.kind          (kind),
		.status        (status),
		.family_code   (family_code),
		.body_byte     (body_byte),
		.in_parameters (in_parameters),
		.last          (last)
	);

endmodule
